FILE: rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, types and constants of the 3x3 fixed-point matrix inverter.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int unsigned DATA_W = 32;   // Q16.16 entry
  localparam int unsigned N_ENT  = 9;    // entries of one matrix
  localparam int unsigned PROD_W = 64;   // entry times entry
  localparam int unsigned COF_W  = 65;   // cofactor, Q33.32
  localparam int unsigned PART_W = 65;   // 33 x 32 partial product
  localparam int unsigned DET_W  = 98;   // determinant, Q48.48 with margin
  localparam int unsigned MAG_W  = 64;   // cofactor magnitude
  localparam int unsigned REM_W  = 98;   // divider remainder and divisor
  localparam int unsigned QUO_W  = 33;   // quotient bits kept by the divider

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [N_ENT-1:0] matrix_t;

  // Operand indexes of each adjugate entry: p*q - s*t
  localparam logic [3:0] COF_IDX [N_ENT][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Per-matrix data that rides along the divider pipeline
  typedef struct packed {
    logic [REM_W-1:0] dmag;
    logic             dneg;
    logic             zero;
    logic [N_ENT-1:0] cneg;
    logic [N_ENT-1:0] big;
  } side_t;

  typedef struct packed {
    logic singular;
    logic saturated;
  } flags_t;

endpackage

FILE: rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a signed Q16.16 3x3 matrix by the adjugate method, saturated.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  input   | in_valid_i/in_stall_o | a00_i .. a22_i
//  output  | out_valid_o/out_stall_i | r00_o .. r22_o, singular_o, saturated_o
//
//  One matrix per cycle sustained while the output is not stalled.
//  Latency is set by the 33-step restoring divider, one quotient bit a stage.
//  Reset clears the queue and all valid bits; no clearing pass.
//  A stalled valid result freezes the whole back pipe; the front queue keeps
//  accepting until it is full.
module matrix3x3_inverse #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] a00_i, a01_i, a02_i,
  input  logic [31:0] a10_i, a11_i, a12_i,
  input  logic [31:0] a20_i, a21_i, a22_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] r00_o, r01_o, r02_o,
  output logic [31:0] r10_o, r11_o, r12_o,
  output logic [31:0] r20_o, r21_o, r22_o,
  output logic        singular_o,
  output logic        saturated_o
);
  import m3i_pkg::*;

  matrix_t           in_mat, head;
  logic              full, head_valid, take;
  logic [DATA_W-1:0] res [N_ENT];
  flags_t            flags;

  assign in_mat = {a22_i, a21_i, a20_i, a12_i, a11_i, a10_i, a02_i, a01_i, a00_i};
  assign in_stall_o = full;

  m3i_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i && !full),
    .data_i       (in_mat),
    .full_o       (full),
    .pop_i        (take),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  m3i_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res),
    .flags_o      (flags)
  );

  assign r00_o = res[0];
  assign r01_o = res[1];
  assign r02_o = res[2];
  assign r10_o = res[3];
  assign r11_o = res[4];
  assign r12_o = res[5];
  assign r20_o = res[6];
  assign r21_o = res[7];
  assign r22_o = res[8];
  assign singular_o  = flags.singular;
  assign saturated_o = flags.saturated;

endmodule

FILE: rtl/m3i_queue.sv
// ----------------------------------------------------------------------------
// m3i_queue
// Front end: accepts matrices and buffers them ahead of the arithmetic pipe.
// ----------------------------------------------------------------------------
module m3i_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  m3i_pkg::matrix_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output m3i_pkg::matrix_t head_o
);
  import m3i_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  matrix_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Store incoming transaction
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/m3i_div_step.sv
// ----------------------------------------------------------------------------
// m3i_div_step
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
module m3i_div_step (
  input  logic [m3i_pkg::REM_W-1:0] rem_i,
  input  logic [m3i_pkg::REM_W-1:0] div_i,
  input  logic                      bit_i,
  output logic [m3i_pkg::REM_W-1:0] rem_o,
  output logic                      q_o
);
  import m3i_pkg::*;

  logic [REM_W-1:0] shifted;

  assign shifted = {rem_i[REM_W-2:0], bit_i};
  assign q_o     = (shifted >= div_i);
  assign rem_o   = q_o ? shifted - div_i : shifted;

endmodule

FILE: rtl/m3i_back.sv
// ----------------------------------------------------------------------------
// m3i_back
// Back end: cofactors, determinant, 33-step divider and saturation, pipelined.
// ----------------------------------------------------------------------------
module m3i_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  m3i_pkg::matrix_t           head_i,
  output logic                       take_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [m3i_pkg::DATA_W-1:0] res_o [m3i_pkg::N_ENT],
  output m3i_pkg::flags_t            flags_o
);
  import m3i_pkg::*;

  logic en;
  logic [5:0] fv_q;
  logic [QUO_W:0] dv_q;
  logic ov_q;

  logic signed [PROD_W-1:0] pp_q [2*N_ENT];
  word_t                    a1_q [3], a2_q [3];
  logic signed [COF_W-1:0]  c2_q [N_ENT], c3_q [N_ENT], c4_q [N_ENT], c5_q [N_ENT];
  logic signed [PART_W-1:0] hi_q [3], lo_q [3];
  logic signed [DET_W-1:0]  term_q [3];
  logic signed [DET_W-1:0]  det_q;
  logic [MAG_W-1:0]         cm_q [N_ENT];
  side_t                    side6_q;

  logic [REM_W-1:0] rem_q [QUO_W+1][N_ENT];
  logic [QUO_W-1:0] quo_q [QUO_W+1][N_ENT];
  side_t            side_q [QUO_W+1];
  logic             nb0_q [N_ENT];

  logic [DATA_W-1:0] res_q [N_ENT];
  flags_t            flags_q;

  // Whole pipe moves unless a finished result is held
  assign en          = !(ov_q && out_stall_i);
  assign take_o      = en && head_valid_i;
  assign out_valid_o = ov_q;
  assign res_o       = res_q;
  assign flags_o     = flags_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      dv_q <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      fv_q <= {fv_q[4:0], head_valid_i};
      dv_q <= {dv_q[QUO_W-1:0], fv_q[5]};
      ov_q <= dv_q[QUO_W];
    end
  end

  // Products, cofactors, determinant and magnitudes
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N_ENT; k++) begin
        pp_q[2*k]   <= $signed(head_i[COF_IDX[k][0]]) * $signed(head_i[COF_IDX[k][1]]);
        pp_q[2*k+1] <= $signed(head_i[COF_IDX[k][2]]) * $signed(head_i[COF_IDX[k][3]]);
        c2_q[k] <= {pp_q[2*k][PROD_W-1], pp_q[2*k]}
                 - {pp_q[2*k+1][PROD_W-1], pp_q[2*k+1]};
        c3_q[k] <= c2_q[k];
        c4_q[k] <= c3_q[k];
        c5_q[k] <= c4_q[k];
        cm_q[k] <= c5_q[k][COF_W-1] ? MAG_W'(-c5_q[k]) : MAG_W'(c5_q[k]);
        side6_q.cneg[k] <= c5_q[k][COF_W-1];
      end
      for (int j = 0; j < 3; j++) begin
        a1_q[j] <= head_i[j];
        a2_q[j] <= a1_q[j];
        hi_q[j] <= $signed(c2_q[3*j][COF_W-1:32]) * $signed(a2_q[j]);
        lo_q[j] <= $signed({1'b0, c2_q[3*j][31:0]}) * $signed(a2_q[j]);
        term_q[j] <= ({{(DET_W-PART_W){hi_q[j][PART_W-1]}}, hi_q[j]} <<< 32)
                   + {{(DET_W-PART_W){lo_q[j][PART_W-1]}}, lo_q[j]};
      end
      det_q <= term_q[0] + term_q[1] + term_q[2];
      side6_q.dmag <= det_q[DET_W-1] ? REM_W'(-det_q) : REM_W'(det_q);
      side6_q.dneg <= det_q[DET_W-1];
      side6_q.zero <= (det_q == '0);
      side6_q.big  <= '0;
    end
  end

  // Quotient range check and divider load
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].dmag <= side6_q.dmag;
      side_q[0].dneg <= side6_q.dneg;
      side_q[0].zero <= side6_q.zero;
      side_q[0].cneg <= side6_q.cneg;
      for (int k = 0; k < N_ENT; k++) begin
        side_q[0].big[k] <= {(REM_W + 1 - MAG_W)'(0), cm_q[k]} >= {side6_q.dmag, 1'b0};
        rem_q[0][k] <= {(REM_W - MAG_W + 1)'(0), cm_q[k][MAG_W-1:1]};
        quo_q[0][k] <= '0;
        nb0_q[k]    <= cm_q[k][0];
      end
    end
  end

  // Divider stages, one quotient bit each
  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    logic [REM_W-1:0] rem_n [N_ENT];
    logic             qb    [N_ENT];
    for (genvar k = 0; k < N_ENT; k++) begin : g_ent
      m3i_div_step u_step (
        .rem_i (rem_q[s][k]),
        .div_i (side_q[s].dmag),
        .bit_i ((s == 0) ? nb0_q[k] : 1'b0),
        .rem_o (rem_n[k]),
        .q_o   (qb[k])
      );
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[s+1] <= side_q[s];
        for (int k = 0; k < N_ENT; k++) begin
          rem_q[s+1][k] <= rem_n[k];
          quo_q[s+1][k] <= {quo_q[s][k][QUO_W-2:0], qb[k]};
        end
      end
    end
  end

  // Saturate, sign and pack the result
  logic [DATA_W-1:0] res_d [N_ENT];
  flags_t            flags_d;
  always_comb begin
    logic [QUO_W-1:0] q;
    logic             neg;
    logic             clamp;
    logic             any_sat;
    any_sat = 1'b0;
    for (int k = 0; k < N_ENT; k++) begin
      q   = quo_q[QUO_W][k];
      neg = side_q[QUO_W].cneg[k] ^ side_q[QUO_W].dneg;
      if (!neg) begin
        clamp    = side_q[QUO_W].big[k] | q[32] | q[31];
        res_d[k] = clamp ? SAT_MAX : q[DATA_W-1:0];
      end else begin
        clamp    = side_q[QUO_W].big[k] | q[32] | (q[31] & (|q[30:0]));
        res_d[k] = clamp ? SAT_MIN : -q[DATA_W-1:0];
      end
      if (side_q[QUO_W].zero) begin
        res_d[k] = '0;
        clamp    = 1'b0;
      end
      any_sat = any_sat | clamp;
    end
    flags_d.singular  = side_q[QUO_W].zero;
    flags_d.saturated = any_sat;
  end

  // Hold result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q   <= res_d;
      flags_q <= flags_d;
    end
  end

endmodule

FILE: rtl/m3i_checker.sv
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks of the matrix inverter, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] r00_o, r01_o, r02_o,
  input logic [31:0] r10_o, r11_o, r12_o,
  input logic [31:0] r20_o, r21_o, r22_o,
  input logic        singular_o,
  input logic        saturated_o
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(r00_o) && $stable(r11_o)
      && $stable(r22_o) && $stable(singular_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // Singular matrix gives an all-zero, unclamped result
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> !saturated_o && r00_o == 0 && r01_o == 0
      && r02_o == 0 && r10_o == 0 && r11_o == 0 && r12_o == 0 && r20_o == 0
      && r21_o == 0 && r22_o == 0)
    else $error("singular result not zero");

  // A clamp shows up as a rail value in some entry
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      r00_o[30:0] == {31{~r00_o[31]}} || r01_o[30:0] == {31{~r01_o[31]}} ||
      r02_o[30:0] == {31{~r02_o[31]}} || r10_o[30:0] == {31{~r10_o[31]}} ||
      r11_o[30:0] == {31{~r11_o[31]}} || r12_o[30:0] == {31{~r12_o[31]}} ||
      r20_o[30:0] == {31{~r20_o[31]}} || r21_o[30:0] == {31{~r21_o[31]}} ||
      r22_o[30:0] == {31{~r22_o[31]}})
    else $error("saturated without a rail value");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (.*);
